// ===== hdl/tks_pkg.sv =====
// Package: shared types and constants for the top-k largest selector.
`default_nettype none
package tks_pkg;

  localparam int MAX_KEEP_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int KEEP_W       = 5;
  localparam int IDX_W        = 7;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    end_of_stream;
  } tks_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] ranked_value;
    logic                    last_ranked;
  } tks_out_t;

  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [VAL_W-1:0] key;
  } tks_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/tks_cell.sv =====
// One slot of the sorted chain: insert with shift-down, or shift toward the output.
`default_nettype none
module tks_cell
  import tks_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire tks_ctl_t                ctl,
  input  wire logic                    en,
  input  wire logic signed [VAL_W-1:0] left_val,
  input  wire logic                    left_valid,
  input  wire logic                    left_gt,
  input  wire logic signed [VAL_W-1:0] right_val,
  input  wire logic                    right_valid,
  output logic signed [VAL_W-1:0]      val,
  output logic                         valid_eff,
  output logic                         gt
);

  logic signed [VAL_W-1:0] held;
  logic                    valid;

  assign valid_eff = valid && en;
  assign gt        = !valid_eff || (ctl.key > held);
  assign val       = held;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= right_val;
    end else if (ctl.insert && gt) begin
      held <= left_gt ? left_val : ctl.key;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.insert) begin
      valid <= en && (valid_eff || left_valid);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/top_k_largest_select.sv =====
// Top level: register port, request handshakes and the chain of sorted cells.
//
//  channel | direction | handshake                | payload
//  item    | in        | item_valid / item_ready  | item  (value, end_of_stream)
//  rank    | out       | rank_valid / rank_ready  | rank  (ranked_value, last_ranked)
//  config  | in        | psel / penable / pready  | paddr, pwdata, prdata (keep_count)
//
// One value is taken per cycle; the chain compares it against every slot in parallel.
// After the final value the chain drains one result per cycle from slot 0, largest first;
// no value is taken while it drains. It gives all kept values, at most MAX_KEEP.
// Reset empties the chain and sets keep_count to 10. A stalled result holds the chain.
`default_nettype none
module top_k_largest_select
  import tks_pkg::*;
#(
  parameter int MAX_KEEP = MAX_KEEP_DEF
)(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire tks_in_t           item,
  output logic                   rank_valid,
  input  wire logic              rank_ready,
  output tks_out_t               rank,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [KEEP_W-1:0]       keep_count;
  logic                    draining;
  tks_ctl_t                ctl;
  logic signed [VAL_W-1:0] cval [MAX_KEEP];
  logic [MAX_KEEP-1:0]     cvalid;
  logic [MAX_KEEP-1:0]     cgt;
  logic                    take;
  logic                    give;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? DATA_W'(keep_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

  assign item_ready = !draining;
  assign take       = item_valid && item_ready;
  assign rank_valid = draining;
  assign give       = rank_valid && rank_ready;

  assign ctl.insert = take;
  assign ctl.shift  = give;
  assign ctl.key    = item.value;

  assign rank.ranked_value = cval[0];
  generate
    if (MAX_KEEP > 1) begin : g_last
      assign rank.last_ranked = !cvalid[1];
    end else begin : g_last1
      assign rank.last_ranked = 1'b1;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (take && item.end_of_stream) begin
      draining <= 1'b1;
    end else if (give && rank.last_ranked) begin
      draining <= 1'b0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_KEEP; i++) begin : g_cell
      localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
      logic                    en;
      logic signed [VAL_W-1:0] lval;
      logic                    lvalid;
      logic                    lgt;
      logic signed [VAL_W-1:0] rval;
      logic                    rvalid;

      assign en = (IDX == '0) || (IDX < IDX_W'(keep_count));

      if (i == 0) begin : g_head
        assign lval   = '0;
        assign lvalid = 1'b1;
        assign lgt    = 1'b0;
      end else begin : g_mid
        assign lval   = cval[i-1];
        assign lvalid = cvalid[i-1];
        assign lgt    = cgt[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_tail
        assign rval   = '0;
        assign rvalid = 1'b0;
      end else begin : g_body
        assign rval   = cval[i+1];
        assign rvalid = cvalid[i+1];
      end

      tks_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .en          (en),
        .left_val    (lval),
        .left_valid  (lvalid),
        .left_gt     (lgt),
        .right_val   (rval),
        .right_valid (rvalid),
        .val         (cval[i]),
        .valid_eff   (cvalid[i]),
        .gt          (cgt[i])
      );
    end
  endgenerate

endmodule
`default_nettype wire
